[sv/fbfill_pkg.sv]
// fbfill_pkg: shared widths, command kinds and register indexes for the
// framebuffer fill and blend core; used by the interfaces and the core module
// no dependencies

package fbfill_pkg;

	localparam int KIND_W   = 2;
	localparam int POS_W    = 12;
	localparam int SIZE_W   = 12;
	localparam int COLOR_W  = 24;
	localparam int ALPHA_W  = 8;
	localparam int COUNT_W  = 17;
	localparam int IMG_W    = 9;
	localparam int COORD_W  = 14;
	localparam int CFG_IDX_W = 2;

	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;

	localparam logic [IMG_W-1:0] IMG_RESET = 9'd256;

	localparam logic [KIND_W-1:0] KIND_FILL  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BLEND = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	typedef logic [COLOR_W-1:0] color_t;
	typedef logic [COUNT_W-1:0] count_t;

endpackage

[sv/fbfill_if.sv]
// fbfill_if: command and result channel interfaces, valid/ready handshake
// depends on fbfill_pkg

interface fbfill_cmd_if import fbfill_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [KIND_W-1:0]         kind;
	logic signed [POS_W-1:0]   x_pos;
	logic signed [POS_W-1:0]   y_pos;
	logic [SIZE_W-1:0]         box_width;
	logic [SIZE_W-1:0]         box_height;
	color_t                    color;
	logic [ALPHA_W-1:0]        alpha;

	modport source (output valid, kind, x_pos, y_pos, box_width, box_height, color, alpha,
		input ready);
	modport sink (input valid, kind, x_pos, y_pos, box_width, box_height, color, alpha,
		output ready);
endinterface

interface fbfill_res_if import fbfill_pkg::*; ();
	logic   valid;
	logic   ready;
	color_t read_color;
	count_t pixels_written;

	modport source (output valid, read_color, pixels_written, input ready);
	modport sink (input valid, read_color, pixels_written, output ready);
endinterface

[sv/fbfill_ram.sv]
// fbfill_ram: generic single-write, single-read ram with registered read data
// no dependencies

module fbfill_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/framebuffer_fill_and_blend_core.sv]
// framebuffer_fill_and_blend_core: rgb888 frame store with clipped box fill,
// single-pixel alpha blend and pixel read, one command item at a time
// depends on fbfill_pkg, fbfill_if, fbfill_ram
//
// channel   dir  handshake       payload
// cmd       in   valid/ready     kind, x_pos, y_pos, box_width, box_height, color, alpha
// res       out  valid/ready     read_color, pixels_written
// cfg       in   cfg_we          cfg_idx, cfg_data (image_width, image_height)
//
// fill writes each covered pixel, one store write per cycle
// blend steps: read, capture, one shared multiplier and /255 stage per channel, write
// read steps: read, capture; a miss or unused kind goes from setup straight to done
// cmd ready is high only when the sequencer is idle; a result waiting in the output
// register holds the sequencer in its last state until the slot frees
// reset sets both image sizes to 256; the store has no reset

module framebuffer_fill_and_blend_core import fbfill_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	fbfill_cmd_if.sink           cmd,
	fbfill_res_if.source         res,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [IMG_W-1:0]     cfg_data
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int XW    = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;
	localparam int YW    = MAX_HEIGHT > 1 ? $clog2(MAX_HEIGHT) : 1;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SETUP = 4'd1;
	localparam logic [3:0] S_FILL  = 4'd2;
	localparam logic [3:0] S_RD    = 4'd3;
	localparam logic [3:0] S_CAP   = 4'd4;
	localparam logic [3:0] S_MUL   = 4'd5;
	localparam logic [3:0] S_DIV   = 4'd6;
	localparam logic [3:0] S_WRITE = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	logic [3:0]              state_q;
	logic [IMG_W-1:0]        img_w_q, img_h_q;

	logic [KIND_W-1:0]       kind_q;
	logic signed [POS_W-1:0] x_q, y_q;
	logic [SIZE_W-1:0]       bw_q, bh_q;
	color_t                  color_q;
	logic [ALPHA_W-1:0]      alpha_q;

	logic [XW-1:0]           cx_q, x_lo_q, x_hi_q;
	logic [YW-1:0]           cy_q, y_hi_q;
	count_t                  cnt_q;
	color_t                  dst_q, mix_q, rd_q;
	logic [1:0]              ch_q;
	logic                    neg_s1;
	logic [15:0]             mag_s1;

	logic                    res_valid_q;
	color_t                  res_color_q;
	count_t                  res_count_q;

	// clipping
	logic signed [COORD_W-1:0] x1s, y1s, x2s, y2s, ew_s, eh_s;
	logic signed [COORD_W-1:0] x_lo, x_hi, y_lo, y_hi;
	logic [COORD_W-1:0]        img_w_ext, img_h_ext;
	logic                      box_miss, pix_on;

	assign img_w_ext = {{(COORD_W-IMG_W){1'b0}}, img_w_q};
	assign img_h_ext = {{(COORD_W-IMG_W){1'b0}}, img_h_q};

	always_comb begin
		ew_s = (img_w_ext > COORD_W'(MAX_WIDTH)) ? COORD_W'(MAX_WIDTH) : $signed(img_w_ext);
		eh_s = (img_h_ext > COORD_W'(MAX_HEIGHT)) ? COORD_W'(MAX_HEIGHT) : $signed(img_h_ext);
		x1s  = {{(COORD_W-POS_W){x_q[POS_W-1]}}, x_q};
		y1s  = {{(COORD_W-POS_W){y_q[POS_W-1]}}, y_q};
		x2s  = x1s + $signed({{(COORD_W-SIZE_W){1'b0}}, bw_q}) - 14'sd1;
		y2s  = y1s + $signed({{(COORD_W-SIZE_W){1'b0}}, bh_q}) - 14'sd1;
		box_miss = (bw_q == '0) || (bh_q == '0) || (x2s < 0) || (y2s < 0)
			|| (x1s >= ew_s) || (y1s >= eh_s) || (ew_s == '0) || (eh_s == '0);
		pix_on = (x1s >= 0) && (y1s >= 0) && (x1s < ew_s) && (y1s < eh_s);
		x_lo = (x1s < 0) ? '0 : x1s;
		y_lo = (y1s < 0) ? '0 : y1s;
		x_hi = (x2s >= ew_s) ? ew_s - 14'sd1 : x2s;
		y_hi = (y2s >= eh_s) ? eh_s - 14'sd1 : y2s;
	end

	// store
	logic [AW-1:0] addr;
	logic          ram_we;
	color_t        ram_wdata, ram_rdata;

	assign addr      = AW'(cy_q) * AW'(MAX_WIDTH) + AW'(cx_q);
	assign ram_we    = (state_q == S_FILL) || (state_q == S_WRITE);
	assign ram_wdata = (state_q == S_FILL) ? color_q : mix_q;

	fbfill_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr),
		.wdata (ram_wdata),
		.raddr (addr),
		.rdata (ram_rdata)
	);

	// shared channel mixer
	logic [7:0]          s_ch, d_ch, quo, mixed;
	logic signed [8:0]   diff;
	logic signed [17:0]  prod, prod_abs;
	logic [16:0]         qsum;

	always_comb begin
		s_ch     = color_q[{ch_q, 3'b000} +: 8];
		d_ch     = dst_q[{ch_q, 3'b000} +: 8];
		diff     = $signed({1'b0, s_ch}) - $signed({1'b0, d_ch});
		prod     = diff * $signed({1'b0, alpha_q});
		prod_abs = prod[17] ? -prod : prod;
		qsum     = {1'b0, mag_s1} + 17'd1 + {9'b0, mag_s1[15:8]};
		quo      = qsum[15:8];
		mixed    = neg_s1 ? d_ch - quo : d_ch + quo;
	end

	assign cmd.ready          = (state_q == S_IDLE);
	assign res.valid          = res_valid_q;
	assign res.read_color     = res_color_q;
	assign res.pixels_written = res_count_q;

	logic res_free;
	assign res_free = !res_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= IMG_RESET;
			img_h_q <= IMG_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_IMAGE_WIDTH:  img_w_q <= cfg_data;
				REG_IMAGE_HEIGHT: img_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && res_free) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					case (kind_q)
						KIND_FILL:  state_q <= box_miss ? S_DONE : S_FILL;
						KIND_BLEND: state_q <= pix_on ? S_RD : S_DONE;
						KIND_READ:  state_q <= pix_on ? S_RD : S_DONE;
						default:    state_q <= S_DONE;
					endcase
				end
				S_FILL: begin
					if (cx_q == x_hi_q && cy_q == y_hi_q) begin
						state_q <= S_DONE;
					end
				end
				S_RD:  state_q <= S_CAP;
				S_CAP: state_q <= (kind_q == KIND_BLEND) ? S_MUL : S_DONE;
				S_MUL: state_q <= S_DIV;
				S_DIV: state_q <= (ch_q == 2'd2) ? S_WRITE : S_MUL;
				S_WRITE: state_q <= S_DONE;
				S_DONE: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					kind_q  <= cmd.kind;
					x_q     <= cmd.x_pos;
					y_q     <= cmd.y_pos;
					bw_q    <= cmd.box_width;
					bh_q    <= cmd.box_height;
					color_q <= cmd.color;
					alpha_q <= cmd.alpha;
				end
			end
			S_SETUP: begin
				cnt_q <= '0;
				rd_q  <= '0;
				ch_q  <= 2'd0;
				if (kind_q == KIND_FILL) begin
					cx_q   <= x_lo[XW-1:0];
					cy_q   <= y_lo[YW-1:0];
					x_lo_q <= x_lo[XW-1:0];
					x_hi_q <= x_hi[XW-1:0];
					y_hi_q <= y_hi[YW-1:0];
				end else begin
					cx_q <= x1s[XW-1:0];
					cy_q <= y1s[YW-1:0];
				end
			end
			S_FILL: begin
				cnt_q <= cnt_q + 1'b1;
				if (cx_q == x_hi_q) begin
					cx_q <= x_lo_q;
					cy_q <= cy_q + 1'b1;
				end else begin
					cx_q <= cx_q + 1'b1;
				end
			end
			S_CAP: begin
				dst_q <= ram_rdata;
				if (kind_q == KIND_READ) begin
					rd_q <= ram_rdata;
				end
			end
			S_MUL: begin
				neg_s1 <= prod[17];
				mag_s1 <= prod_abs[15:0];
			end
			S_DIV: begin
				mix_q[{ch_q, 3'b000} +: 8] <= mixed;
				ch_q <= ch_q + 2'd1;
			end
			S_WRITE: begin
				cnt_q <= count_t'(1);
			end
			S_DONE: begin
				if (res_free) begin
					res_color_q <= rd_q;
					res_count_q <= cnt_q;
				end
			end
			default: ;
		endcase
	end

endmodule
